/* hdl/spad_pkg.sv */
// Package for the stepper phase accumulator drive.
// Holds the word and state types, the reset constants and the fixed-point
// constants. It depends on nothing else.
package spad_pkg;

  localparam int unsigned POS_W   = 48;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned COIL_W  = 4;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(256);
  localparam logic [COIL_W-1:0] COILS_RESET = COIL_W'(1);

  // Half a step and one whole step in Q.16.
  localparam logic signed [POS_W-1:0] HALF_STEP = POS_W'(32768);
  localparam logic signed [POS_W-1:0] ONE_STEP  = POS_W'(65536);

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = SPEED_W'(32767);
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

  typedef enum logic {
    FUNC_MOVE = 1'b0,
    FUNC_TICK = 1'b1
  } spad_func_t;

  typedef struct packed {
    logic                        func;
    logic signed [SPEED_W-1:0]   speed;
    logic signed [DIST_W-1:0]    distance;
  } spad_in_t;

  typedef struct packed {
    logic                        busy_res;
    logic [COIL_W-1:0]           coils;
    logic                        stepped;
    logic signed [STEP_W-1:0]    step_count;
  } spad_out_t;

  typedef struct packed {
    logic signed [POS_W-1:0]     position;
    logic signed [POS_W-1:0]     target;
    logic signed [SPEED_W-1:0]   speed;
    logic [STEP_W-1:0]           last_step;
    logic [PHASE_W-1:0]          phase;
    logic [COIL_W-1:0]           coils;
    logic [STEP_W-1:0]           real_steps;
  } spad_state_t;

endpackage

/* hdl/spad_if.sv */
// Valid/ready channel that carries one word of a packed type.
// Used for the command and result channels; depends on nothing.
interface spad_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/spad_step.sv */
// Next-state and result logic for one command or tick word.
// Depends on spad_pkg.
module spad_step (
  input  spad_pkg::spad_state_t   state,
  input  spad_pkg::spad_in_t      word,
  input  logic [15:0]             gain,
  output spad_pkg::spad_state_t   state_nxt,
  output spad_pkg::spad_out_t     result
);
  import spad_pkg::*;

  logic signed [POS_W-1:0]   dist_ext;
  logic signed [POS_W-1:0]   tgt_new;
  logic                      behind;
  logic signed [SPEED_W-1:0] sp_new;
  logic signed [POS_W-1:0]   err;
  logic                      at_target;
  logic signed [32:0]        prod;
  logic signed [POS_W-1:0]   inc;
  logic signed [POS_W-1:0]   pos_new;
  logic signed [POS_W-1:0]   ds;
  logic                      spd_neg;
  logic                      spd_pos;
  logic                      take;
  logic [PHASE_W-1:0]        dir;
  logic [PHASE_W-1:0]        ph_next;
  logic [PHASE_W-1:0]        ph_after;
  logic [COIL_W-1:0]         coils_step;

  always_comb begin
    // Move command: target relative to the current position.
    dist_ext = POS_W'(word.distance);
    tgt_new  = state.position + dist_ext;
    behind   = tgt_new < state.position;
    if (!behind) begin
      sp_new = word.speed;
    end else if (word.speed == SPEED_MIN) begin
      sp_new = SPEED_MAX;
    end else begin
      sp_new = -word.speed;
    end

    // Tick: idle while within half a step of the target.
    err       = state.position - state.target;
    at_target = (err > -HALF_STEP) && (err < HALF_STEP);

    // Q8.8 times Q0.16, then arithmetic shift by 8 floors to Q.16.
    prod    = $signed(33'(state.speed)) * $signed({17'b0, gain});
    inc     = POS_W'($signed(prod[32:8]));
    pos_new = state.position + inc;
    ds      = pos_new - $signed({state.last_step, {FRAC_W{1'b0}}});

    spd_neg = state.speed[SPEED_W-1];
    spd_pos = !spd_neg && (state.speed != '0);
    take    = spd_neg ? (ds <= -ONE_STEP) : (ds >= ONE_STEP);

    // A zero speed steps the phase backwards.
    dir        = spd_pos ? PHASE_W'(1) : PHASE_W'(3);
    ph_next    = state.phase + dir;
    ph_after   = ph_next + dir;
    coils_step = (state.coils | (COIL_W'(1) << ph_next) | (COIL_W'(1) << ph_after))
                 & ~(COIL_W'(1) << state.phase);

    state_nxt       = state;
    result.busy_res = 1'b0;
    result.stepped  = 1'b0;

    unique case (spad_func_t'(word.func))
      FUNC_MOVE: begin
        state_nxt.target = tgt_new;
        state_nxt.speed  = sp_new;
      end
      FUNC_TICK: begin
        if (!at_target) begin
          state_nxt.position = pos_new;
          result.busy_res    = 1'b1;
          if (take) begin
            result.stepped       = 1'b1;
            state_nxt.phase      = ph_next;
            state_nxt.coils      = coils_step;
            state_nxt.real_steps = state.real_steps + (spd_pos ? STEP_W'(1) : '1);
            state_nxt.last_step  = state.last_step + (spd_neg ? '1 : STEP_W'(1));
          end
        end
      end
      default: begin
        state_nxt = state;
      end
    endcase

    result.coils      = state_nxt.coils;
    result.step_count = state_nxt.real_steps;
  end

endmodule

/* hdl/stepper_phase_accumulator_drive.sv */
// Top level of the stepper phase accumulator drive: input register, step
// logic and result register. Depends on spad_pkg, spad_if and spad_step.
//
//  channel   dir  handshake          contents
//  in_word   in   valid / ready      func, speed, distance
//  out_word  out  valid / ready      busy_res, coils, stepped, step_count
//  cfg_*     in   cfg_valid / ready  tick_gain (16 bit)
//
// Each word is held in the input register and evaluated there against the
// drive state; its result and the next state are loaded together into the
// result register and the state register. A new word is taken every cycle
// while the result is not stalled: the combinational position update
// closes the loop from one word to the next.
// Reset (rst_n low, synchronous) clears position, target, speed and step
// counts, puts coil 0 on and loads a gain of 256. A stalled result holds the
// result register, and the input register holds until the result is free.
module stepper_phase_accumulator_drive (
  input  logic          clk,
  input  logic          rst_n,
  spad_if.sink          in_word,
  spad_if.source        out_word,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);
  import spad_pkg::*;

  logic                in_valid_r;
  spad_in_t            in_data_r;
  logic                out_valid_r;
  spad_out_t           out_data_r;
  spad_state_t         state_r;
  spad_state_t         state_nxt;
  spad_out_t           result;
  logic [GAIN_W-1:0]   gain_r;
  logic                fire;

  // The result register is free when empty or being drained this cycle.
  assign fire          = in_valid_r && (!out_valid_r || out_word.ready);
  assign in_word.ready = !in_valid_r || fire;
  assign cfg_ready     = 1'b1;

  assign out_word.valid = out_valid_r;
  assign out_word.data  = out_data_r;

  spad_step u_step (
    .state     (state_r),
    .word      (in_data_r),
    .gain      (gain_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r      <= GAIN_RESET;
      state_r     <= '{position: '0, target: '0, speed: '0, last_step: '0,
                       phase: '0, coils: COILS_RESET, real_steps: '0};
    end else begin
      if (in_word.valid && in_word.ready) begin
        in_valid_r <= 1'b1;
        in_data_r  <= in_word.data;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end

      if (fire) begin
        out_valid_r <= 1'b1;
        out_data_r  <= result;
        state_r     <= state_nxt;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid) begin
        gain_r <= cfg_data;
      end
    end
  end

  // The active coil is always driven.
  a_active_coil_on: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.coils[state_r.phase])
    else $error("active phase coil is off");

  // A word that takes no step leaves the step count alone.
  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !result.stepped) |=> (state_r.real_steps == $past(state_r.real_steps)))
    else $error("step count changed without a step");

  // A step is only reported on a tick away from the target (busy_res set).
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.stepped || out_data_r.busy_res))
    else $error("step reported without motion");

  // With the result register empty the input side never stalls.
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_word.ready)
    else $error("input stalled with an empty result register");

endmodule
